[rtl/bpp_pkg.sv]
// Package for the board position packer: controller states, error codes,
// square and code widths, and the command and status structs between the
// controller and the datapath. No dependencies.
`default_nettype none

package bpp_pkg;

  localparam int unsigned NUM_SQ      = 64;
  localparam int unsigned SQ_W        = 6;
  localparam int unsigned NUM_TYPES   = 6;
  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned MAX_PIECES  = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned KING_TYPE   = 5;
  localparam logic [SQ_W-1:0] KING_FLIP = 6'd56;
  localparam logic [SQ_W-1:0] LAST_SQ   = 6'd63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } bpp_state_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_MANY = 2'd1,
    ERR_UNTYPED  = 2'd2,
    ERR_NO_KING  = 2'd3
  } bpp_err_t;

  typedef struct packed {
    logic            ready;
    logic            load;
    logic            step;
    logic [SQ_W-1:0] sq;
    logic            publish;
  } bpp_cmd_t;

  typedef struct packed {
    logic out_free;
  } bpp_stat_t;

endpackage

`default_nettype wire

[rtl/board_position_packer.sv]
// Top level of the board position packer: joins the controller and the
// datapath. Depends on bpp_pkg, bpp_ctrl and bpp_datapath.
//
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   s_tdata 536 bits, s_tuser 1 bit
// m_*      out        m_tvalid/m_tready   m_tdata 224 bits, m_tuser 2 bits
//
// Each word is loaded, then its squares are scanned one per cycle through
// the board shift registers, and then the result is moved into the output
// register. The output register lets the next word load while a result
// still waits. Reset clears the controller and the output valid flag.
// A stalled output holds the hand-off and the next load; the scan runs on.
`default_nettype none

module board_position_packer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0 up: white_men, black_men, pawn_board, knight_board,
  // bishop_board, rook_board, queen_board, king_board, score_in,
  // game_result, zero fill.
  input  logic [535:0] s_tdata,
  // s_tuser: black_to_move.
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0 up: occupancy, piece_codes_low, piece_codes_high,
  // score_out, result_code, own_king_square, their_king_square, zero fill.
  output logic [223:0] m_tdata,
  // m_tuser: error_code.
  output logic [1:0]   m_tuser
);
  import bpp_pkg::*;

  bpp_cmd_t  cmd;
  bpp_stat_t stat;

  assign s_tready = cmd.ready;

  bpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[rtl/bpp_ctrl.sv]
// Controller of the board position packer: load, square-by-square scan and
// hand-off to the output register. Depends on bpp_pkg.
`default_nettype none

module bpp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  bpp_pkg::bpp_stat_t stat,
  output bpp_pkg::bpp_cmd_t  cmd
);
  import bpp_pkg::*;

  bpp_state_t      state;
  bpp_state_t      state_next;
  logic [SQ_W-1:0] sq_idx;
  logic [SQ_W-1:0] sq_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sq_idx <= '0;
    end else begin
      state  <= state_next;
      sq_idx <= sq_idx_next;
    end
  end

  always_comb begin
    state_next  = state;
    sq_idx_next = sq_idx;
    unique case (state)
      ST_IDLE: begin
        sq_idx_next = '0;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        sq_idx_next = sq_idx + 1'b1;
        if (sq_idx == LAST_SQ) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        sq_idx_next = '0;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next  = ST_IDLE;
        sq_idx_next = '0;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sq = sq_idx;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = s_tvalid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.publish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SCAN) && (sq_idx == '0))
    else $error("scan did not start at square zero after a load");

  a_scan_advances: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (sq_idx != LAST_SQ) |=>
      (state == ST_SCAN) && (sq_idx == $past(sq_idx) + 1'b1))
    else $error("scan did not advance by one square");

  a_publish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (state == ST_IDLE))
    else $error("controller did not return to idle after publishing");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !cmd.step && !cmd.publish)
    else $error("input ready while a word is in progress");

endmodule

`default_nettype wire

[rtl/bpp_datapath.sv]
// Datapath of the board position packer: orientation, board shift registers,
// piece code packing, king search, error tracking and the output register.
// Depends on bpp_pkg.
`default_nettype none

module bpp_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bpp_pkg::bpp_cmd_t  cmd,
  output bpp_pkg::bpp_stat_t stat,
  input  logic [535:0]       s_tdata,
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [223:0]       m_tdata,
  output logic [1:0]         m_tuser
);
  import bpp_pkg::*;

  function automatic logic [NUM_SQ-1:0] flip_ranks(input logic [NUM_SQ-1:0] v);
    logic [NUM_SQ-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  logic [NUM_SQ-1:0] in_board [8];
  logic [NUM_SQ-1:0] or_board [8];
  logic              black;
  logic [15:0]       score_in;
  logic [1:0]        result_in;
  logic [1:0]        result_clamped;

  logic [NUM_SQ-1:0] own_sh;
  logic [NUM_SQ-1:0] opp_sh;
  logic [NUM_SQ-1:0] type_sh [NUM_TYPES];
  logic [NUM_SQ-1:0] occ;
  logic [15:0]       score;
  logic [1:0]        result;
  logic [CODE_W-1:0] codes [MAX_PIECES];
  logic [CNT_W-1:0]  piece_cnt;
  bpp_err_t          err;
  logic              own_found;
  logic              opp_found;
  logic [SQ_W-1:0]   own_sq;
  logic [SQ_W-1:0]   opp_sq;

  logic              occupied;
  logic              typed;
  logic [TYPE_W-1:0] ptype;
  bpp_err_t          err_final;
  logic [127:0]      codes_flat;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_board[i] = s_tdata[NUM_SQ*i +: NUM_SQ];
      or_board[i] = s_tuser ? flip_ranks(in_board[i]) : in_board[i];
    end
    black          = s_tuser;
    score_in       = s_tdata[527:512];
    result_in      = s_tdata[529:528];
    result_clamped = (result_in == 2'd3) ? 2'd2 : result_in;
  end

  always_comb begin
    occupied = own_sh[0] | opp_sh[0];
    typed    = 1'b0;
    ptype    = '0;
    for (int p = NUM_TYPES - 1; p >= 0; p--) begin
      if (type_sh[p][0]) begin
        typed = 1'b1;
        ptype = TYPE_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_cnt <= '0;
      err       <= ERR_NONE;
    end else if (cmd.load) begin
      own_sh    <= black ? or_board[1] : or_board[0];
      opp_sh    <= black ? or_board[0] : or_board[1];
      occ       <= or_board[0] | or_board[1];
      for (int p = 0; p < NUM_TYPES; p++) begin
        type_sh[p] <= or_board[p+2];
      end
      score     <= black ? 16'(16'd0 - score_in) : score_in;
      result    <= black ? 2'(2'd2 - result_clamped) : result_clamped;
      for (int k = 0; k < MAX_PIECES; k++) begin
        codes[k] <= '0;
      end
      piece_cnt <= '0;
      err       <= ERR_NONE;
      own_found <= 1'b0;
      opp_found <= 1'b0;
      own_sq    <= '0;
      opp_sq    <= '0;
    end else if (cmd.step) begin
      own_sh <= own_sh >> 1;
      opp_sh <= opp_sh >> 1;
      for (int p = 0; p < NUM_TYPES; p++) begin
        type_sh[p] <= type_sh[p] >> 1;
      end
      if ((err == ERR_NONE) && occupied) begin
        if (piece_cnt[CNT_W-1]) begin
          err <= ERR_TOO_MANY;
        end else if (!typed) begin
          err <= ERR_UNTYPED;
        end else begin
          codes[piece_cnt[CNT_W-2:0]] <= {opp_sh[0], ptype};
          piece_cnt                   <= piece_cnt + 1'b1;
        end
      end
      if (type_sh[KING_TYPE][0]) begin
        if (own_sh[0] && !own_found) begin
          own_found <= 1'b1;
          own_sq    <= cmd.sq;
        end
        if (opp_sh[0] && !opp_found) begin
          opp_found <= 1'b1;
          opp_sq    <= cmd.sq;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PIECES; k++) begin
      codes_flat[CODE_W*k +: CODE_W] = codes[k];
    end
    if (err != ERR_NONE) begin
      err_final = err;
    end else if (!own_found || !opp_found) begin
      err_final = ERR_NO_KING;
    end else begin
      err_final = ERR_NONE;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      m_tuser <= err_final;
      if (err_final != ERR_NONE) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {2'b00, opp_sq ^ KING_FLIP, own_sq, result, score,
                    codes_flat, occ};
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    piece_cnt <= CNT_W'(MAX_PIECES))
    else $error("piece count ran past the limit");

  a_error_zeroes_data: assert property (@(posedge clk) disable iff (rst)
    cmd.publish && (err_final != ERR_NONE) |=> (m_tdata == '0))
    else $error("error word carries nonzero data");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    cmd.step && (err != ERR_NONE) |=> (err == $past(err)))
    else $error("first error was overwritten during the scan");

endmodule

`default_nettype wire
